FILE: rtl/nru_pkg.sv
// Shared types and constants for the NRU page replacement core.
// No dependencies; the core and nru_mod_step in rtl/ refer to this package.
`default_nettype none

package nru_pkg;

    // Fixed field widths of the reference and result transfers
    localparam int PAGE_NUM_W = 7;
    localparam int PICK_W     = 8;
    localparam int FRAME_W    = 4;
    localparam int COUNT_W    = 32;

    // Width of the shared remainder step datapath
    localparam int MOD_W      = 8;

    // One page reference
    typedef struct packed {
        logic [PAGE_NUM_W-1:0] vpage;
        logic                  written;
        logic [PICK_W-1:0]     pick;
    } ref_item_t;

    // One replacement result
    typedef struct packed {
        logic                  fault;
        logic [FRAME_W-1:0]    frame;
        logic                  evicted_valid;
        logic [PAGE_NUM_W-1:0] evicted_page;
        logic [COUNT_W-1:0]    fault_count;
    } res_item_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_SCAN,
        ST_MOD,
        ST_SEL,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/nru_page_replacement_core.sv
// Top level of the NRU page replacement core: sequencer, frame table and remainder unit.
// Depends on nru_pkg, nru_frame_mem and nru_mod_step.
`default_nettype none

// Takes one page reference per transfer and returns one result per reference.
// The block works on one reference at a time and is not ready until its result
// has been loaded into the output register. A reference first has its page number
// reduced modulo PAGES (only when PAGES < 128), then the frame table is scanned
// through its single read port, one frame per cycle, until a hit or until all used
// frames are seen; a fault then takes a free frame if there is one. When all frames
// are full, the pick value is reduced modulo the class size in 8 steps of the shared
// remainder unit and the table is scanned again to find the victim. Resident pages
// always carry R = 1 (R is never cleared), so only the M bit, kept per frame, sets
// the class.
module nru_page_replacement_core #(
    parameter int PAGES  = 128,
    parameter int FRAMES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               ref_valid,
    output logic                    ref_ready,
    input  wire nru_pkg::ref_item_t ref_item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output nru_pkg::res_item_t      res_item
);

    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int FW = $clog2(FRAMES);
    localparam int UW = FW + 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int DW = PW + 1;
    localparam bit NEED_RED = (PAGES < 128);
    localparam logic [nru_pkg::MOD_W-1:0] PAGES_D  = nru_pkg::MOD_W'(PAGES);
    localparam logic [nru_pkg::MOD_W-1:0] FRAMES_D = nru_pkg::MOD_W'(FRAMES);
    localparam logic [UW-1:0] FRAMES_U = UW'(FRAMES);
    localparam logic [2:0] STEP_LAST = 3'(nru_pkg::MOD_W - 1);

    nru_pkg::state_t state_reg, state_next;

    logic [UW-1:0]                 idx_reg, idx_next;
    logic                          chk_v_reg, chk_v_next;
    logic [FW-1:0]                 chk_idx_reg, chk_idx_next;
    logic [2:0]                    step_reg, step_next;
    logic [nru_pkg::MOD_W-1:0]     rem_reg, rem_next;
    logic [nru_pkg::MOD_W-1:0]     src_reg, src_next;
    logic [nru_pkg::MOD_W-1:0]     div_reg, div_next;
    logic [nru_pkg::PICK_W-1:0]    pick_reg, pick_next;
    logic                          wr_reg, wr_next;
    logic [PW-1:0]                 page_reg, page_next;
    logic [UW-1:0]                 used_reg, used_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [CW-1:0]                 seen_reg, seen_next;
    logic                          cls_m_reg, cls_m_next;
    logic                          hit_reg, hit_next;
    logic [FW-1:0]                 slot_reg, slot_next;
    logic [PW-1:0]                 ev_reg, ev_next;
    logic                          evv_reg, evv_next;
    logic                          newm_reg, newm_next;
    logic [nru_pkg::COUNT_W-1:0]   faults_reg, faults_next;
    logic                          res_valid_reg, res_valid_next;
    nru_pkg::res_item_t            res_reg, res_next;

    logic [nru_pkg::MOD_W-1:0]     unit_out;
    logic [DW-1:0]                 rd_data;
    logic [PW-1:0]                 rd_page;
    logic                          rd_m;
    logic                          mem_we;
    logic                          accept;
    logic                          out_free;
    logic                          scan_hit;
    logic                          scan_end;
    logic                          sel_found;
    logic                          step_last;

    // Frame table
    nru_frame_mem #(
        .DEPTH (FRAMES),
        .AW    (FW),
        .DW    (DW)
    ) u_frame_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_reg),
        .wdata ({page_reg, newm_reg}),
        .raddr (idx_reg[FW-1:0]),
        .rdata (rd_data)
    );

    // Shared remainder step, used for page reduction and the victim pick
    nru_mod_step u_mod_step (
        .rem_in  (rem_reg),
        .bit_in  (src_reg[step_reg]),
        .divisor (div_reg),
        .rem_out (unit_out)
    );

    // Status terms shared by the next-state and datapath logic
    always_comb
    begin
        rd_page   = rd_data[DW-1:1];
        rd_m      = rd_data[0];
        accept    = ref_valid && ref_ready;
        out_free  = !res_valid_reg || res_ready;
        scan_hit  = chk_v_reg && (rd_page == page_reg);
        scan_end  = !chk_v_reg && (idx_reg == used_reg);
        sel_found = chk_v_reg && (rd_m == cls_m_reg) &&
                    (seen_reg == CW'(rem_reg));
        step_last = (step_reg == 3'd0);
        mem_we    = (state_reg == nru_pkg::ST_WRITE) && out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nru_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = NEED_RED ? nru_pkg::ST_PRED : nru_pkg::ST_SCAN;
                end
            end
            nru_pkg::ST_PRED:
            begin
                if (step_last)
                begin
                    state_next = nru_pkg::ST_SCAN;
                end
            end
            nru_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = nru_pkg::ST_WRITE;
                end
                else if (scan_end)
                begin
                    state_next = (used_reg < FRAMES_U) ? nru_pkg::ST_WRITE
                                                       : nru_pkg::ST_MOD;
                end
            end
            nru_pkg::ST_MOD:
            begin
                if (step_last)
                begin
                    state_next = nru_pkg::ST_SEL;
                end
            end
            nru_pkg::ST_SEL:
            begin
                if (sel_found)
                begin
                    state_next = nru_pkg::ST_WRITE;
                end
            end
            nru_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = nru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nru_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        idx_next       = idx_reg;
        chk_v_next     = 1'b0;
        chk_idx_next   = chk_idx_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        src_next       = src_reg;
        div_next       = div_reg;
        pick_next      = pick_reg;
        wr_next        = wr_reg;
        page_next      = page_reg;
        used_next      = used_reg;
        cnt_next       = cnt_reg;
        seen_next      = seen_reg;
        cls_m_next     = cls_m_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        ev_next        = ev_reg;
        evv_next       = evv_reg;
        newm_next      = newm_reg;
        faults_next    = faults_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        ref_ready      = (state_reg == nru_pkg::ST_IDLE);

        // Issue one frame table read per cycle while scanning
        if ((state_reg == nru_pkg::ST_SCAN || state_reg == nru_pkg::ST_SEL) &&
            (idx_reg < used_reg))
        begin
            chk_v_next   = 1'b1;
            chk_idx_next = idx_reg[FW-1:0];
            idx_next     = idx_reg + UW'(1);
        end

        case (state_reg)
            nru_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    src_next  = {1'b0, ref_item.vpage};
                    page_next = PW'(ref_item.vpage);
                    pick_next = ref_item.pick;
                    wr_next   = ref_item.written;
                    div_next  = PAGES_D;
                    rem_next  = '0;
                    step_next = STEP_LAST;
                    idx_next  = '0;
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    evv_next  = 1'b0;
                    ev_next   = '0;
                end
            end
            nru_pkg::ST_PRED:
            begin
                rem_next  = unit_out;
                step_next = step_reg - 3'd1;
                if (step_last)
                begin
                    page_next = PW'(unit_out);
                end
            end
            nru_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    hit_next   = 1'b1;
                    slot_next  = chk_idx_reg;
                    newm_next  = rd_m | wr_reg;
                    chk_v_next = 1'b0;
                end
                else if (chk_v_reg && !rd_m)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (scan_end)
                begin
                    newm_next = wr_reg;
                    if (used_reg < FRAMES_U)
                    begin
                        // Free frame: fill in order
                        slot_next = used_reg[FW-1:0];
                        used_next = used_reg + UW'(1);
                    end
                    else
                    begin
                        // Lowest class is clean pages if any, else all frames
                        div_next   = (cnt_reg != '0) ? nru_pkg::MOD_W'(cnt_reg) : FRAMES_D;
                        cls_m_next = (cnt_reg == '0);
                        src_next   = pick_reg;
                        rem_next   = '0;
                        step_next  = STEP_LAST;
                    end
                end
            end
            nru_pkg::ST_MOD:
            begin
                rem_next  = unit_out;
                step_next = step_reg - 3'd1;
                if (step_last)
                begin
                    idx_next  = '0;
                    seen_next = '0;
                end
            end
            nru_pkg::ST_SEL:
            begin
                if (sel_found)
                begin
                    slot_next  = chk_idx_reg;
                    ev_next    = rd_page;
                    evv_next   = 1'b1;
                    chk_v_next = 1'b0;
                end
                else if (chk_v_reg && (rd_m == cls_m_reg))
                begin
                    seen_next = seen_reg + CW'(1);
                end
            end
            nru_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    if (!hit_reg && (faults_reg != '1))
                    begin
                        faults_next = faults_reg + nru_pkg::COUNT_W'(1);
                    end
                    res_valid_next         = 1'b1;
                    res_next.fault         = !hit_reg;
                    res_next.frame         = nru_pkg::FRAME_W'(slot_reg);
                    res_next.evicted_valid = evv_reg;
                    res_next.evicted_page  = nru_pkg::PAGE_NUM_W'(ev_reg);
                    res_next.fault_count   = (!hit_reg && (faults_reg != '1))
                                             ? faults_reg + nru_pkg::COUNT_W'(1)
                                             : faults_reg;
                end
            end
            default:
            begin
                chk_v_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nru_pkg::ST_IDLE;
            chk_v_reg     <= 1'b0;
            used_reg      <= '0;
            faults_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_v_reg     <= chk_v_next;
            used_reg      <= used_next;
            faults_reg    <= faults_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        src_reg     <= src_next;
        div_reg     <= div_next;
        pick_reg    <= pick_next;
        wr_reg      <= wr_next;
        page_reg    <= page_next;
        cnt_reg     <= cnt_next;
        seen_reg    <= seen_next;
        cls_m_reg   <= cls_m_next;
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        ev_reg      <= ev_next;
        evv_reg     <= evv_next;
        newm_reg    <= newm_next;
        res_reg     <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

`default_nettype wire

FILE: rtl/nru_frame_mem.sv
// Frame table memory: one entry per frame holding the resident page and its M bit.
// One write port, one registered read port. Uses no package items.
`default_nettype none

module nru_frame_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/nru_mod_step.sv
// One restoring remainder step: shift in one dividend bit, subtract divisor if it fits.
// Depends on nru_pkg for the datapath width.
`default_nettype none

module nru_mod_step (
    input  wire logic [nru_pkg::MOD_W-1:0] rem_in,
    input  wire logic                      bit_in,
    input  wire logic [nru_pkg::MOD_W-1:0] divisor,
    output logic      [nru_pkg::MOD_W-1:0] rem_out
);

    logic [nru_pkg::MOD_W-1:0] shifted;

    // Remainder stays below a divisor of at most 127, so the top bit drops out
    always_comb
    begin
        shifted = {rem_in[nru_pkg::MOD_W-2:0], bit_in};
        if (shifted >= divisor)
        begin
            rem_out = shifted - divisor;
        end
        else
        begin
            rem_out = shifted;
        end
    end

endmodule

`default_nettype wire

FILE: dv/nru_replacement_checker.sv
`timescale 1ns / 1ps
// Scoreboard for nru_page_replacement_core: tracks page residency and R/M bits,
// predicts every result and compares it with the result transfers. Depends on nru_pkg.
module nru_replacement_checker #(
    parameter int PAGES  = 128,
    parameter int FRAMES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ref_valid,
    input  logic               ref_ready,
    input  nru_pkg::ref_item_t ref_item,
    input  logic               res_valid,
    input  logic               res_ready,
    input  nru_pkg::res_item_t res_item,
    output int                 mismatches,
    output int                 results_due,
    output int                 refs_seen,
    output int                 hits_seen,
    output int                 evictions_seen
);

    localparam int NUM_CLASSES = 4;

    // Shadow copy of the replacement state
    logic [PAGES-1:0]               r_bits;
    logic [PAGES-1:0]               m_bits;
    logic [nru_pkg::PAGE_NUM_W-1:0] slot_page [FRAMES];
    int                             frames_filled;
    logic [nru_pkg::COUNT_W-1:0]    faults_total;

    // Results predicted for accepted references, oldest first
    nru_pkg::res_item_t due_results [$];

    // Apply one reference to the shadow state and return the result it gives
    function automatic nru_pkg::res_item_t nru_lookup(nru_pkg::ref_item_t item);
        nru_pkg::res_item_t             res;
        logic [nru_pkg::PAGE_NUM_W-1:0] page;
        logic                           hit;
        int                             slot;
        int                             cls;
        int                             target;
        int                             seen;
        logic                           found;
        int                             class_size [NUM_CLASSES];
        res  = '0;
        page = nru_pkg::PAGE_NUM_W'(item.vpage % PAGES);
        hit  = 1'b0;
        slot = 0;
        for (int j = 0; j < frames_filled; j++)
        begin
            if (!hit && slot_page[j] == page)
            begin
                hit  = 1'b1;
                slot = j;
            end
        end
        if (hit)
        begin
            // Hit: R set, M only ever set by a write
            r_bits[page] = 1'b1;
            if (item.written)
                m_bits[page] = 1'b1;
        end
        else
        begin
            res.fault = 1'b1;
            if (frames_filled < FRAMES)
            begin
                slot = frames_filled;
                frames_filled++;
            end
            else
            begin
                // Full table: lowest non-empty (R,M) class, member pick mod size
                for (int c = 0; c < NUM_CLASSES; c++)
                    class_size[c] = 0;
                for (int j = 0; j < FRAMES; j++)
                    class_size[{r_bits[slot_page[j]], m_bits[slot_page[j]]}]++;
                cls = 0;
                while (cls < NUM_CLASSES - 1 && class_size[cls] == 0)
                    cls++;
                target = (class_size[cls] != 0) ? int'(item.pick) % class_size[cls] : 0;
                seen   = 0;
                found  = 1'b0;
                for (int j = 0; j < FRAMES; j++)
                begin
                    if (!found && int'({r_bits[slot_page[j]], m_bits[slot_page[j]]}) == cls)
                    begin
                        if (seen == target)
                        begin
                            slot  = j;
                            found = 1'b1;
                        end
                        else
                            seen++;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_page  = slot_page[slot];
            end
            // Page arrives with R set and M equal to the written flag
            slot_page[slot] = page;
            r_bits[page]    = 1'b1;
            m_bits[page]    = item.written;
            if (faults_total != '1)
                faults_total++;
        end
        res.frame       = nru_pkg::FRAME_W'(slot);
        res.fault_count = faults_total;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expv, actv);
        end
    endtask

    // Watch both channels; compare results first, then queue the new prediction
    always @(posedge clk)
    begin : monitor
        nru_pkg::res_item_t expd;
        nru_pkg::res_item_t pred;
        if (!rst_n)
        begin
            r_bits         = '0;
            m_bits         = '0;
            for (int j = 0; j < FRAMES; j++)
                slot_page[j] = '0;
            frames_filled  = 0;
            faults_total   = '0;
            due_results.delete();
            mismatches     = 0;
            results_due    = 0;
            refs_seen      = 0;
            hits_seen      = 0;
            evictions_seen = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transfer with nothing expected, expected none, actual %p",
                             $time, res_item);
                end
                else
                begin
                    expd = due_results.pop_front();
                    check_field("fault", expd.fault, res_item.fault);
                    check_field("frame", expd.frame, res_item.frame);
                    check_field("evicted_valid", expd.evicted_valid, res_item.evicted_valid);
                    check_field("evicted_page", expd.evicted_page, res_item.evicted_page);
                    check_field("fault_count", expd.fault_count, res_item.fault_count);
                end
            end
            if (ref_valid && ref_ready)
            begin
                pred = nru_lookup(ref_item);
                due_results.push_back(pred);
                refs_seen++;
                if (!pred.fault)
                    hits_seen++;
                if (pred.evicted_valid)
                    evictions_seen++;
            end
            results_due = due_results.size();
        end
    end

endmodule

FILE: dv/nru_page_replacement_core_tb.sv
`timescale 1ns / 1ps
// Top of the NRU page replacement testbench: clock, reset, reference stimulus,
// result back-pressure and verdict. Depends on nru_pkg and nru_replacement_checker.
module nru_page_replacement_core_tb;

    localparam int PAGES        = 128;
    localparam int FRAMES       = 16;
    localparam int TOTAL_ITEMS  = 400;
    localparam int CALM_ITEMS   = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 64;
    localparam int POOL_SIZE    = 20;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               ref_valid = 1'b0;
    logic               ref_ready;
    nru_pkg::ref_item_t ref_item  = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    nru_pkg::res_item_t res_item;

    // Idling switch, and a request for the long output hold-off
    logic idle_on  = 1'b1;
    logic hold_req = 1'b0;

    int mismatches;
    int results_due;
    int refs_seen;
    int hits_seen;
    int evictions_seen;
    int items_sent   = 0;
    int quiet_cycles = 0;

    logic [nru_pkg::PAGE_NUM_W-1:0] page_pool [POOL_SIZE];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    nru_page_replacement_core #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .ref_valid (ref_valid),
        .ref_ready (ref_ready),
        .ref_item  (ref_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    nru_replacement_checker #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .ref_valid      (ref_valid),
        .ref_ready      (ref_ready),
        .ref_item       (ref_item),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_item       (res_item),
        .mismatches     (mismatches),
        .results_due    (results_due),
        .refs_seen      (refs_seen),
        .hits_seen      (hits_seen),
        .evictions_seen (evictions_seen)
    );

    // Offer one reference, called and returning at a falling edge
    task automatic send_ref(input logic [nru_pkg::PAGE_NUM_W-1:0] page, input logic wr,
                            input logic [nru_pkg::PICK_W-1:0] pick);
        nru_pkg::ref_item_t item;
        int                 gap;
        item.vpage   = page;
        item.written = wr;
        item.pick    = pick;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            ref_valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge clk);
        end
        ref_item  <= item;
        ref_valid <= 1'b1;
        do
            @(posedge clk);
        while (!ref_ready);
        @(negedge clk);
        items_sent++;
        if (items_sent >= TOTAL_ITEMS - CALM_ITEMS)
            idle_on <= 1'b0;
    endtask

    // Random references drawn from a small set of pages: mix of hits and faults
    task automatic run_working_set();
        int n;
        int len;
        n   = $urandom_range(4, POOL_SIZE);
        len = $urandom_range(8, 24);
        for (int k = 0; k < n; k++)
            page_pool[k] = nru_pkg::PAGE_NUM_W'($urandom_range(0, PAGES - 1));
        repeat (len)
            send_ref(page_pool[$urandom_range(0, n - 1)], 1'($urandom_range(0, 1)),
                     nru_pkg::PICK_W'($urandom_range(0, 255)));
    endtask

    // Write a table's worth of random pages three times over, then send one random reference
    task automatic run_dirty_sweep();
        for (int k = 0; k < FRAMES; k++)
            page_pool[k] = nru_pkg::PAGE_NUM_W'($urandom_range(0, PAGES - 1));
        repeat (3)
        begin
            for (int k = 0; k < FRAMES; k++)
                send_ref(page_pool[k], 1'b1, nru_pkg::PICK_W'($urandom_range(0, 255)));
        end
        send_ref(nru_pkg::PAGE_NUM_W'($urandom_range(0, PAGES - 1)),
                 1'($urandom_range(0, 1)), nru_pkg::PICK_W'($urandom_range(0, 255)));
    endtask

    // Scattered references across the whole page range
    task automatic run_noise();
        repeat ($urandom_range(1, 5))
            send_ref(nru_pkg::PAGE_NUM_W'($urandom_range(0, PAGES - 1)),
                     1'($urandom_range(0, 1)), nru_pkg::PICK_W'($urandom_range(0, 255)));
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                res_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                res_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                res_ready <= 1'b1;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (ref_valid && ref_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and verdict
    initial
    begin
        int choice;
        int sweeps;
        sweeps = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: page and pick extremes, hits with and without write, table fill
        send_ref(7'd0, 1'b0, 8'd0);
        send_ref(7'd127, 1'b1, 8'd255);
        send_ref(7'd0, 1'b1, 8'd0);
        send_ref(7'd127, 1'b0, 8'd255);
        for (int k = 1; k <= FRAMES - 2; k++)
            send_ref(7'(k), k[0], 8'(k * 17));
        // Full table: replacements, then a read hit on a freshly loaded clean page
        send_ref(7'h55, 1'b0, 8'd255);
        send_ref(7'h2A, 1'b1, 8'd0);
        send_ref(7'h55, 1'b0, 8'd3);
        send_ref(7'd100, 1'b0, 8'd128);

        // Random part, opening with a long output hold-off
        hold_req <= 1'b1;
        while (items_sent < TOTAL_ITEMS)
        begin
            choice = $urandom_range(0, 9);
            if (choice < 5)
                run_working_set();
            else if (choice < 7 && sweeps < 2)
            begin
                run_dirty_sweep();
                sweeps++;
            end
            else
                run_noise();
        end
        ref_valid <= 1'b0;

        wait (results_due == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d references: %0d hits, %0d faults, %0d replacements,",
                 refs_seen, hits_seen, refs_seen - hits_seen, evictions_seen);
        $display("with random idling on both channels and one %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && results_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
